>>> rtl/rtnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtnh_pkg;
  localparam int FRAC = 16;
  localparam int MAX_TRI = 65536;
  localparam int CNT_W = 16;
  localparam logic [30:0] DIST_MAX = 31'h7FFFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_CROSS, ST_DOT, ST_CHECK, ST_DIV_T, ST_DIV_U, ST_DIV_V,
    ST_UPDATE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic cross_step;
    logic dot_step;
    logic check;
    logic div_start;
    logic [1:0] div_sel;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic seq_done;
    logic div_done;
    logic pass;
    logic better;
    logic last;
  } stat_t;

  localparam logic [1:0] DIV_T = 2'd0;
  localparam logic [1:0] DIV_U = 2'd1;
  localparam logic [1:0] DIV_V = 2'd2;

  localparam logic [2:0] REG_OX = 3'd0;
  localparam logic [2:0] REG_OY = 3'd1;
  localparam logic [2:0] REG_OZ = 3'd2;
  localparam logic [2:0] REG_DX = 3'd3;
  localparam logic [2:0] REG_DY = 3'd4;
  localparam logic [2:0] REG_DZ = 3'd5;

  // fixed multiply, floor of product >> FRAC (arithmetic shift is floor)
  function automatic logic signed [47:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    fmul = p[63:FRAC];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (x < -50'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/rtnh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rtnh_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire rtnh_pkg::stat_t stat,
  output rtnh_pkg::cmd_t cmd
);
  import rtnh_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_CROSS;
      ST_CROSS: if (stat.seq_done) state_next = ST_DOT;
      ST_DOT:   if (stat.seq_done) state_next = ST_CHECK;
      ST_CHECK: state_next = stat.pass ? ST_DIV_T : (stat.last ? ST_OUT : ST_IDLE);
      ST_DIV_T: if (stat.div_done) state_next = stat.better ? ST_DIV_U
                                                : (stat.last ? ST_OUT : ST_IDLE);
      ST_DIV_U: if (stat.div_done) state_next = ST_DIV_V;
      ST_DIV_V: if (stat.div_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = stat.last ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIFF:  cmd.diff = 1'b1;
      ST_CROSS: cmd.cross_step = 1'b1;
      ST_DOT:   cmd.dot_step = 1'b1;
      ST_CHECK: begin
        cmd.check = 1'b1;
        cmd.div_start = stat.pass;
        cmd.div_sel = DIV_T;
      end
      ST_DIV_T: begin
        cmd.div_sel = DIV_T;
        cmd.div_start = stat.div_done && stat.better;
        if (stat.div_done && stat.better) cmd.div_sel = DIV_U;
      end
      ST_DIV_U: begin
        cmd.div_sel = DIV_U;
        cmd.div_start = stat.div_done;
        if (stat.div_done) cmd.div_sel = DIV_V;
      end
      ST_DIV_V: cmd.div_sel = DIV_V;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.emit = out_ready;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/rtnh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rtnh_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [288:0] tri_in,
  input  wire rtnh_pkg::cmd_t cmd,
  output rtnh_pkg::stat_t stat,
  output logic [81:0] result
);
  import rtnh_pkg::*;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] va [3], vb [3], vc [3];
  logic signed [31:0] e1 [3], e2 [3], w [3];
  logic signed [31:0] n [3], q [3];
  logic signed [63:0] det, uu, vv, tt;
  logic last;
  logic [2:0] step;
  logic signed [47:0] pa, pb;
  logic signed [31:0] ma0, mb0, ma1, mb1;

  // ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OX: org[0] <= cfg_data;
        REG_OY: org[1] <= cfg_data;
        REG_OZ: org[2] <= cfg_data;
        REG_DX: dir[0] <= cfg_data;
        REG_DY: dir[1] <= cfg_data;
        REG_DZ: dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the two shared multipliers
  always_comb begin
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
    if (cmd.cross_step) begin
      case (step)
        3'd0: begin ma0 = e1[1]; mb0 = e2[2]; ma1 = e1[2]; mb1 = e2[1]; end
        3'd1: begin ma0 = e1[2]; mb0 = e2[0]; ma1 = e1[0]; mb1 = e2[2]; end
        3'd2: begin ma0 = e1[0]; mb0 = e2[1]; ma1 = e1[1]; mb1 = e2[0]; end
        3'd3: begin ma0 = w[1]; mb0 = dir[2]; ma1 = w[2]; mb1 = dir[1]; end
        3'd4: begin ma0 = w[2]; mb0 = dir[0]; ma1 = w[0]; mb1 = dir[2]; end
        default: begin ma0 = w[0]; mb0 = dir[1]; ma1 = w[1]; mb1 = dir[0]; end
      endcase
    end else begin
      case (step[1:0])
        2'd0: begin ma0 = dir[0]; mb0 = n[0]; ma1 = q[0]; mb1 = e2[0]; end
        2'd1: begin ma0 = dir[1]; mb0 = n[1]; ma1 = q[1]; mb1 = e2[1]; end
        2'd2: begin ma0 = dir[2]; mb0 = n[2]; ma1 = q[2]; mb1 = e2[2]; end
        default: ;
      endcase
    end
  end
  assign pa = fmul(ma0, mb0);
  assign pb = fmul(ma1, mb1);

  logic signed [47:0] p2, p3;
  logic [1:0] di;
  assign di = step[1:0] == 2'd3 ? 2'd0 : step[1:0];
  assign p2 = fmul(q[di], e1[di]);
  assign p3 = fmul(n[di], w[di]);

  // sign-corrected dot products for the hit test and the divider
  logic signed [63:0] sdet, su, sv, st;
  assign sdet = det[63] ? -det : det;
  assign su = det[63] ? -uu : uu;
  assign sv = det[63] ? -vv : vv;
  assign st = det[63] ? -tt : tt;

  // divider
  logic signed [63:0] dsel;
  logic [30:0] dnum;
  logic [63:0] drem;
  logic [30:0] dq;
  logic [4:0] dcnt;
  logic dbusy, dsat, ddone;
  logic [1:0] dkind;
  logic [30:0] dres;
  logic [30:0] best_t, cur_t;
  logic [16:0] best_u, best_v;
  logic [CNT_W-1:0] best_i, cur_i, cnt;
  logic any_hit, pass;
  logic [64:0] rsh;
  assign rsh = {drem, dnum[30]};
  assign dres = dsat ? DIST_MAX : dq;

  always_comb begin
    case (cmd.div_sel)
      DIV_U: dsel = su;
      DIV_V: dsel = sv;
      default: dsel = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      dbusy <= 1'b0;
      ddone <= 1'b0;
      any_hit <= 1'b0;
      best_t <= DIST_MAX;
      best_u <= '0;
      best_v <= '0;
      best_i <= '0;
      cnt <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < 3; i++) begin
          va[i] <= tri_in[32*i +: 32];
          vb[i] <= tri_in[96 + 32*i +: 32];
          vc[i] <= tri_in[192 + 32*i +: 32];
        end
        last <= tri_in[288];
        step <= '0;
      end
      if (cmd.diff) begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= sat32(50'(vb[i]) - 50'(va[i]));
          e2[i] <= sat32(50'(vc[i]) - 50'(va[i]));
          w[i]  <= sat32(50'(org[i]) - 50'(va[i]));
        end
        det <= '0; uu <= '0; vv <= '0; tt <= '0;
      end
      if (cmd.cross_step) begin
        if (step < 3'd3) n[step[1:0]] <= sat32(50'(pa) - 50'(pb));
        else q[2'(step - 3'd3)] <= sat32(50'(pa) - 50'(pb));
        step <= step == 3'd5 ? 3'd0 : step + 3'd1;
      end
      if (cmd.dot_step) begin
        det <= det + 64'(pa);
        uu <= uu - 64'(pb);
        vv <= vv + 64'(p2);
        tt <= tt - 64'(p3);
        step <= step + 3'd1;
      end
      if (cmd.check && det[63]) begin
        det <= -det; uu <= -uu; vv <= -vv; tt <= -tt;
      end
      // restoring division: flag an integer part too large, then 31 quotient bits
      ddone <= dbusy && (dcnt == 5'd30);
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt <= '0;
        dkind <= cmd.div_sel;
        drem <= 64'(dsel >>> (31 - FRAC));
        dnum <= 31'(dsel << FRAC);
        dq <= '0;
        dsat <= (65'(dsel) >= (65'(sdet) << (31 - FRAC)));
      end else if (dbusy) begin
        dnum <= dnum << 1;
        if (rsh >= 65'(det)) begin
          drem <= 64'(rsh - 65'(det));
          dq <= {dq[29:0], 1'b1};
        end else begin
          drem <= rsh[63:0];
          dq <= {dq[29:0], 1'b0};
        end
        if (dcnt == 5'd30) dbusy <= 1'b0;
        dcnt <= dcnt + 5'd1;
      end
      if (stat.div_done) begin
        case (dkind)
          DIV_U: best_u <= dres[16:0];
          DIV_V: best_v <= dres[16:0];
          default: cur_t <= dres;
        endcase
      end
      if (cmd.update) begin
        best_t <= cur_t;
        best_i <= cur_i;
        any_hit <= 1'b1;
      end
      if (cmd.check) begin
        cur_i <= cnt;
        cnt <= (32'(cnt) + 1 >= MAX_TRI) ? '0 : cnt + 1'b1;
      end
      if (cmd.emit) begin
        any_hit <= 1'b0;
        best_t <= DIST_MAX;
        best_u <= '0;
        best_v <= '0;
        best_i <= '0;
        cnt <= '0;
      end
    end
  end

  assign pass = (sdet != 0) && !su[63] && !sv[63] && (su <= sdet)
              && ((su + sv) <= sdet) && (st > 0);

  assign stat = '{
    seq_done: cmd.cross_step ? (step == 3'd5) : (step == 3'd2),
    div_done: ddone,
    pass: pass,
    better: (dres != 0) && (dres < best_t),
    last: last
  };

  assign result = any_hit ? {best_i, best_v, best_u, best_t, 1'b1} : '0;
endmodule
`default_nettype wire

>>> rtl/ray_triangle_nearest_hit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Ray / triangle nearest-hit unit.
// Write the ray (origin x,y,z then direction x,y,z, signed Q16.16) through
// cfg_we/cfg_index/cfg_data while idle. Stream triangles on s_axis: tdata
// holds vertex A, B, C (x,y,z each, 32 bits), tuser is last_triangle.
// Each triangle goes through load, difference, six cross-product steps and
// three dot steps on the shared multipliers, then check, and a miss ends
// there; a candidate at positive distance runs the restoring divider for t,
// and a nearer hit runs it for u and v too and then an update. On the
// triangle marked last, one result appears on m_axis and the block holds it
// until m_axis_tready; no new triangle is taken until then. Then the kept
// hit and the triangle count clear. Reset clears the ray registers to zero
// and the kept hit to none.
module ray_triangle_nearest_hit_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // vertex_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire logic [287:0] s_axis_tdata,
  // last_triangle
  input  wire logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // hit_distance, bary_u, bary_v, triangle_index, zero pad
  output logic [87:0] m_axis_tdata,
  // hit_found
  output logic m_axis_tuser
);
  import rtnh_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [81:0] result;

  rtnh_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .stat, .cmd
  );
  rtnh_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .tri_in({s_axis_tuser, s_axis_tdata}), .cmd, .stat, .result
  );

  assign m_axis_tuser = result[0];
  assign m_axis_tdata = {7'd0, result[81:1]};

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
endmodule
`default_nettype wire
